// ----- rtl/ptf_pkg.sv -----
// ----------------------------------------------------------------------------
// ptf_pkg
// Types and codes shared by the process table queue modules.
// ----------------------------------------------------------------------------
package ptf_pkg;

  localparam int ACT_W  = 3;
  localparam int PID_W  = 16;
  localparam int NAME_W = 64;
  localparam int STS_W  = 2;
  localparam int RUN_W  = 2;

  localparam logic [ACT_W-1:0] ACT_ADD       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DEQUEUE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUSPEND   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TERMINATE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FORK      = 3'd4;
  localparam logic [ACT_W-1:0] ACT_EXEC      = 3'd5;

  localparam logic [STS_W-1:0] STS_DONE     = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL     = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY    = 2'd2;
  localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd3;

  localparam logic [RUN_W-1:0] RUN_RUNNING    = 2'd0;
  localparam logic [RUN_W-1:0] RUN_SUSPENDED  = 2'd1;
  localparam logic [RUN_W-1:0] RUN_TERMINATED = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [PID_W-1:0]  pid;
    logic [PID_W-1:0]  ppid;
    logic [NAME_W-1:0] name_tag;
  } in_item_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [PID_W-1:0]  out_pid;
    logic [NAME_W-1:0] out_name;
    logic [RUN_W-1:0]  out_state;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic             push;
    logic             pop;
    logic             rd_head;
    logic             srch_start;
    logic             srch_step;
    logic             wr_state;
    logic [RUN_W-1:0] state_val;
    logic             wr_name;
    logic             res_load;
    logic [STS_W-1:0] res_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             empty;
    logic             full;
    logic             hit;
    logic             miss;
    logic             out_free;
  } dp_stat_t;

endpackage

// ----- rtl/ptf_ram.sv -----
// ----------------------------------------------------------------------------
// ptf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/ptf_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptf_ctrl
// Sequencer for the process table: decodes each beat and steps the datapath.
// ----------------------------------------------------------------------------
module ptf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ptf_pkg::dp_stat_t stat,
  output ptf_pkg::ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_POP    = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic [ptf_pkg::STS_W-1:0] sts_r, sts_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sts_r   <= ptf_pkg::STS_DONE;
    end else begin
      state_r <= state_nxt;
      sts_r   <= sts_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    sts_nxt   = sts_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RESULT;
        sts_nxt   = ptf_pkg::STS_DONE;
        case (stat.action)
          ptf_pkg::ACT_ADD: begin
            if (stat.full) begin
              sts_nxt = ptf_pkg::STS_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          ptf_pkg::ACT_DEQUEUE: begin
            if (stat.empty) begin
              sts_nxt = ptf_pkg::STS_EMPTY;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_POP;
            end
          end
          ptf_pkg::ACT_SUSPEND, ptf_pkg::ACT_TERMINATE, ptf_pkg::ACT_EXEC: begin
            if (stat.empty) begin
              sts_nxt = ptf_pkg::STS_EMPTY;
            end else begin
              cmd.srch_start = 1'b1;
              state_nxt      = S_SEARCH;
            end
          end
          ptf_pkg::ACT_FORK: begin
            if (stat.empty) begin
              sts_nxt = ptf_pkg::STS_EMPTY;
            end else if (stat.full) begin
              sts_nxt = ptf_pkg::STS_FULL;
            end else begin
              cmd.srch_start = 1'b1;
              state_nxt      = S_SEARCH;
            end
          end
          default: begin
            sts_nxt = ptf_pkg::STS_DONE;
          end
        endcase
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        sts_nxt   = ptf_pkg::STS_DONE;
        state_nxt = S_RESULT;
      end
      S_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (stat.hit) begin
          sts_nxt   = ptf_pkg::STS_DONE;
          state_nxt = S_RESULT;
          case (stat.action)
            ptf_pkg::ACT_SUSPEND: begin
              cmd.wr_state  = 1'b1;
              cmd.state_val = ptf_pkg::RUN_SUSPENDED;
            end
            ptf_pkg::ACT_TERMINATE: begin
              cmd.wr_state  = 1'b1;
              cmd.state_val = ptf_pkg::RUN_TERMINATED;
            end
            ptf_pkg::ACT_EXEC: begin
              cmd.wr_name = 1'b1;
            end
            ptf_pkg::ACT_FORK: begin
              cmd.push = 1'b1;
            end
            default: begin
              cmd.wr_state = 1'b0;
            end
          endcase
        end else if (stat.miss) begin
          sts_nxt   = ptf_pkg::STS_NOTFOUND;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = sts_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/ptf_datapath.sv -----
// ----------------------------------------------------------------------------
// ptf_datapath
// Entry RAMs, queue pointers, pid search walker and result register.
// ----------------------------------------------------------------------------
module ptf_datapath #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ptf_pkg::in_item_t  in_data,
  input  logic               out_stall,
  output logic               out_valid,
  output ptf_pkg::out_item_t out_data,
  input  ptf_pkg::ctl_cmd_t  cmd,
  output ptf_pkg::dp_stat_t  stat
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ptf_pkg::in_item_t  item_r;
  ptf_pkg::out_item_t out_data_r, out_data_nxt;
  logic               out_valid_r;

  logic [IDX_W-1:0] head_r, tail_r, srch_idx_r, cmp_idx_r;
  logic [CNT_W-1:0] count_r, srch_cnt_r;
  logic             cmp_valid_r;

  logic [ptf_pkg::PID_W-1:0]  key;
  logic                       issue;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [ptf_pkg::PID_W-1:0]  rd_pid;
  logic [ptf_pkg::NAME_W-1:0] rd_name;
  logic [ptf_pkg::RUN_W-1:0]  rd_state;
  logic [IDX_W-1:0]           name_wr_addr, state_wr_addr;
  logic [ptf_pkg::NAME_W-1:0] name_wr_data;
  logic [ptf_pkg::RUN_W-1:0]  state_wr_data;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
    wrap_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign key     = (item_r.action == ptf_pkg::ACT_FORK) ? item_r.ppid : item_r.pid;
  assign issue   = cmd.srch_step && (srch_cnt_r != count_r);
  assign rd_en   = cmd.rd_head || issue;
  assign rd_addr = cmd.rd_head ? head_r : srch_idx_r;

  assign name_wr_addr  = cmd.push ? tail_r : cmp_idx_r;
  assign name_wr_data  = item_r.name_tag;
  assign state_wr_addr = cmd.push ? tail_r : cmp_idx_r;
  assign state_wr_data = cmd.push ? ptf_pkg::RUN_RUNNING : cmd.state_val;

  ptf_ram #(.WIDTH(ptf_pkg::PID_W), .DEPTH(DEPTH)) u_pid_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail_r),
    .wr_data (item_r.pid),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_pid)
  );

  ptf_ram #(.WIDTH(ptf_pkg::NAME_W), .DEPTH(DEPTH)) u_name_ram (
    .clk     (clk),
    .wr_en   (cmd.push || cmd.wr_name),
    .wr_addr (name_wr_addr),
    .wr_data (name_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_name)
  );

  ptf_ram #(.WIDTH(ptf_pkg::RUN_W), .DEPTH(DEPTH)) u_state_ram (
    .clk     (clk),
    .wr_en   (cmd.push || cmd.wr_state),
    .wr_addr (state_wr_addr),
    .wr_data (state_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_state)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else if (cmd.push) begin
      tail_r  <= wrap_next(tail_r);
      count_r <= count_r + 1'b1;
    end else if (cmd.pop) begin
      head_r  <= wrap_next(head_r);
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_valid_r <= 1'b0;
    end else begin
      cmp_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_start) begin
      srch_idx_r <= head_r;
      srch_cnt_r <= '0;
    end else if (issue) begin
      srch_idx_r <= wrap_next(srch_idx_r);
      srch_cnt_r <= srch_cnt_r + 1'b1;
    end
    if (issue) begin
      cmp_idx_r <= srch_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt.status = cmd.res_status;
    if (cmd.res_status == ptf_pkg::STS_DONE) begin
      if (item_r.action == ptf_pkg::ACT_DEQUEUE) begin
        out_data_nxt.out_pid   = rd_pid;
        out_data_nxt.out_name  = rd_name;
        out_data_nxt.out_state = rd_state;
      end else if (item_r.action == ptf_pkg::ACT_FORK) begin
        out_data_nxt.out_pid = item_r.pid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign stat.action   = item_r.action;
  assign stat.empty    = (count_r == '0);
  assign stat.full     = (count_r == CNT_W'(DEPTH));
  assign stat.hit      = cmp_valid_r && (rd_pid == key);
  assign stat.miss     = !cmp_valid_r && (srch_cnt_r == count_r);
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

// ----- rtl/process_table_fifo.sv -----
// ----------------------------------------------------------------------------
// process_table_fifo
// Circular process queue with pid search, one result beat per input beat.
// ----------------------------------------------------------------------------
// One item is handled at a time. Add, error cases and unused actions pass
// through the decode and result states, dequeue through decode, pop and
// result, and suspend, terminate, exec and fork through decode, search and
// result, the search stopping when the key pid (the ppid for fork) is found
// or once every occupied entry has been walked: the pid search reads one
// entry per cycle from head to tail through the single read port of the pid
// RAM. A result waits in the result state while the previous one is held in
// the output register. Entry RAMs are not cleared; only occupied entries are read.
module process_table_fifo #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ptf_pkg::out_item_t out_data
);

  ptf_pkg::ctl_cmd_t ctl_cmd;
  ptf_pkg::dp_stat_t dp_stat;

  ptf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  ptf_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (ctl_cmd),
    .stat      (dp_stat)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in progress");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.res_load |-> (!out_valid || !out_stall))
    else $error("result register loaded while a held beat waits");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    dp_stat.full |-> !ctl_cmd.push)
    else $error("push into a full queue");

  a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ctl_cmd.res_load))
    else $error("result beat without a result load");
`endif

endmodule
